FILE: rtl/core/rlte_pkg.sv
// Types, constants and helper functions shared by the run-length text encoder.
`default_nettype none
package rlte_pkg;

  localparam int unsigned RunLenW    = 7;
  localparam int unsigned CntW       = 4;
  localparam int unsigned PosW       = 3;
  localparam int unsigned ThrW       = 4;
  localparam logic [CntW-1:0] EscLen     = 4'd4;
  localparam logic [CntW-1:0] MaxResults = 4'd8;
  localparam logic [ThrW-1:0] ThrMax     = 4'd9;
  localparam logic [ThrW-1:0] MinEscRst  = 4'd5;
  localparam logic [7:0]      EscByteRst = 8'd47;
  localparam logic [7:0]      DigitZero  = 8'h30;

  typedef enum logic [0:0] {
    CFG_MIN_ESC_RUN = 1'b0,
    CFG_ESC_BYTE    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ESC_POS_MARK = 2'd0,
    ESC_POS_TENS = 2'd1,
    ESC_POS_ONES = 2'd2,
    ESC_POS_CHAR = 2'd3
  } esc_pos_e;

  typedef struct packed {
    logic            esc;
    logic [7:0]      ch;
    logic [3:0]      tens;
    logic [3:0]      ones;
    logic [CntW-1:0] cnt;
  } seg_t;

  typedef struct packed {
    logic err;
    logic eom;
    seg_t a;
    seg_t b;
  } burst_t;

  function automatic logic char_ok(logic [7:0] c);
    logic ok;
    ok = 1'b1;
    if (c >= 8'd126) begin
      ok = 1'b0;
    end else if (c inside {[8'd33:8'd38], 8'd42, 8'd47, 8'd60, [8'd62:8'd64],
                           8'd92, 8'd94, 8'd95, 8'd124}) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic seg_t make_seg(logic [7:0] ch, logic [RunLenW-1:0] len, logic esc);
    seg_t s;
    logic [14:0] prod;
    logic [3:0] tens;
    logic [RunLenW-1:0] rem;
    prod   = 15'(len) * 15'd205;
    tens   = prod[14:11];
    rem    = len - (RunLenW'(tens) * 7'd10);
    s.esc  = esc;
    s.ch   = ch;
    s.tens = tens;
    s.ones = rem[3:0];
    s.cnt  = esc ? EscLen : len[CntW-1:0];
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/run_length_text_encoder.sv
// Top level of the run-length text encoder with escaped count form.
// The first result byte of an item appears in the cycle after the item is accepted.
// Items are taken at one item per cycle while each gives at most one result byte and the output
// is not stalled; an item with more result bytes holds the input until its last byte is taken.
// Reset clears the open run and the output valid flag and loads the register defaults.
`default_nettype none
module run_length_text_encoder #(
  parameter int unsigned MAX_RUN = 99
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // char_in
  input  wire logic       s_axis_tlast,  // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // out_byte
  output logic [1:0]      m_axis_tuser,  // bad_input, is_last
  output logic            m_axis_tlast   // message_done
);
  import rlte_pkg::*;

  logic [ThrW-1:0]    min_esc_q;
  logic [7:0]         esc_byte_q;
  logic [7:0]         run_char_q, run_char_d;
  logic [RunLenW-1:0] run_len_q, run_len_d;
  logic [ThrW-1:0]    thr;
  logic [RunLenW-1:0] thr_w, new_len;
  logic [7:0]         new_char;
  logic [CntW-1:0]    tail;
  logic               accept, can_load, extend, esc_a, load;
  burst_t             burst;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid & can_load;

  assign thr   = (min_esc_q > ThrMax) ? ThrMax : min_esc_q;
  assign thr_w = {3'd0, thr};
  assign tail  = (thr <= 4'd1) ? EscLen : 4'd1;

  always_comb begin
    extend     = (run_len_q != '0) && (s_axis_tdata == run_char_q) &&
                 (run_len_q < RunLenW'(MAX_RUN));
    new_char   = extend ? run_char_q : s_axis_tdata;
    new_len    = extend ? run_len_q + 7'd1 : 7'd1;
    esc_a      = (run_len_q >= thr_w) ||
                 (s_axis_tlast && (({1'b0, run_len_q} + {4'd0, tail}) > {4'd0, MaxResults}));
    burst.err  = 1'b0;
    burst.eom  = s_axis_tlast;
    burst.a    = make_seg(run_char_q, run_len_q, esc_a);
    burst.b    = make_seg(new_char, new_len, new_len >= thr_w);
    run_char_d = new_char;
    run_len_d  = new_len;
    if (extend || (run_len_q == '0)) begin
      burst.a.cnt = '0;
    end
    if (!s_axis_tlast) begin
      burst.b.cnt = '0;
    end else begin
      run_char_d = '0;
      run_len_d  = '0;
    end
    if (!char_ok(s_axis_tdata)) begin
      burst.err   = 1'b1;
      burst.a     = make_seg(8'd0, 7'd1, 1'b0);
      burst.b.cnt = '0;
      run_char_d  = '0;
      run_len_d   = '0;
    end
    load = accept && ((burst.a.cnt | burst.b.cnt) != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_char_q <= '0;
      run_len_q  <= '0;
      min_esc_q  <= MinEscRst;
      esc_byte_q <= EscByteRst;
    end else begin
      if (accept) begin
        run_char_q <= run_char_d;
        run_len_q  <= run_len_d;
      end
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_ESC_RUN: min_esc_q  <= cfg_data_i[ThrW-1:0];
          CFG_ESC_BYTE:    esc_byte_q <= cfg_data_i;
          default:         esc_byte_q <= esc_byte_q;
        endcase
      end
    end
  end

  rlte_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .burst_i       (burst),
    .esc_byte_i    (esc_byte_q),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/core/rlte_serial.sv
// Result register and byte serializer that emits one encoded byte per cycle while the output is ready.
`default_nettype none
module rlte_serial (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire rlte_pkg::burst_t burst_i,
  input  wire logic [7:0]      esc_byte_i,
  output logic                 can_load_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // out_byte
  output logic [1:0]           m_axis_tuser,  // bad_input, is_last
  output logic                 m_axis_tlast   // message_done
);
  import rlte_pkg::*;

  burst_t         burst_q;
  logic           vld_q, vld_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] pos_w, total, idx;
  logic           last, fire, in_a;
  seg_t           seg;

  assign pos_w = {1'b0, pos_q};
  assign total = burst_q.a.cnt + burst_q.b.cnt;
  assign last  = (pos_w + 4'd1) == total;
  assign fire  = vld_q & m_axis_tready;
  assign in_a  = pos_w < burst_q.a.cnt;
  assign seg   = in_a ? burst_q.a : burst_q.b;
  assign idx   = in_a ? pos_w : pos_w - burst_q.a.cnt;

  always_comb begin
    m_axis_tdata = seg.ch;
    if (seg.esc) begin
      case (esc_pos_e'(idx[1:0]))
        ESC_POS_MARK: m_axis_tdata = esc_byte_i;
        ESC_POS_TENS: m_axis_tdata = DigitZero + {4'd0, seg.tens};
        ESC_POS_ONES: m_axis_tdata = DigitZero + {4'd0, seg.ones};
        ESC_POS_CHAR: m_axis_tdata = seg.ch;
        default:      m_axis_tdata = seg.ch;
      endcase
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = {burst_q.err, last};
  assign m_axis_tlast  = burst_q.eom & last;
  assign can_load_o    = ~vld_q | (fire & last);

  always_comb begin
    vld_d = vld_q;
    pos_d = pos_q;
    if (load_i) begin
      vld_d = 1'b1;
      pos_d = '0;
    end else if (fire) begin
      if (last) begin
        vld_d = 1'b0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pos_q <= '0;
    end else begin
      vld_q <= vld_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule
`default_nettype wire
